FILE: rtl/u8g_pkg.sv
// Shared types, constants and the glyph slot lookup for the UTF-8 glyph slot decoder.
`timescale 1ns / 1ps

package u8g_pkg;

    localparam int CP_W      = 21;
    localparam int SLOT_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int REPL_W    = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISSING_SLOT     = 2'd1;

    localparam logic [CP_W-1:0]   RESET_REPLACEMENT_CODE = 21'h00FFFD;
    localparam logic [SLOT_W-1:0] RESET_MISSING_SLOT     = 8'd95;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic [SLOT_W-1:0] glyph_slot;
        logic              is_replacement;
        logic              last_of_run;
    } out_item_t;

    // Work for the back end: a run of replacements, then optionally one decoded code point
    typedef struct packed {
        logic [REPL_W-1:0] repl_cnt;
        logic              has_value;
        logic [CP_W-1:0]   value;
    } job_t;

    typedef struct packed {
        logic [CP_W-1:0]   replacement_code;
        logic [SLOT_W-1:0] missing_slot;
    } cfg_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [CP_W-1:0]   cp,
                                                  input logic [SLOT_W-1:0] missing);
        logic [CP_W-1:0]   diff;
        logic [SLOT_W-1:0] slot;
        diff = '0;
        slot = missing;
        if (cp >= 21'h000020 && cp <= 21'h00007E)
        begin
            diff = cp - 21'h000020;
            slot = diff[SLOT_W-1:0];
        end
        else if (cp >= 21'h000410 && cp <= 21'h00044F)
        begin
            diff = cp - 21'h000410;
            slot = diff[SLOT_W-1:0] + 8'd96;
        end
        else
        begin
            case (cp)
                21'h000401: slot = 8'd160;
                21'h000451: slot = 8'd161;
                21'h0000AB: slot = 8'd162;
                21'h0000BB: slot = 8'd163;
                21'h002014: slot = 8'd164;
                default:    slot = missing;
            endcase
        end
        return slot;
    endfunction

endpackage

FILE: rtl/u8g_front.sv
// Front end: accepts bytes, tracks the open UTF-8 sequence and posts jobs to the queue.
`timescale 1ns / 1ps

module u8g_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  u8g_pkg::in_item_t in_item,
    input  logic              queue_full,
    output logic              push,
    output u8g_pkg::job_t     job
);
    import u8g_pkg::*;

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [1:0]      needed_reg, needed_next;
    logic [1:0]      seen_reg, seen_next;

    logic              accept;
    logic [BYTE_W-1:0] b;
    logic              eot;
    logic              take_lead;
    logic              lead_repl;
    logic [REPL_W-1:0] flush_cnt;
    logic [1:0]        seen_inc;
    logic [CP_W-1:0]   pc_ext;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign b        = in_item.byte_in;
    assign eot      = in_item.end_of_text;
    assign seen_inc = seen_reg + 2'd1;
    assign pc_ext   = {partial_reg[CP_W-7:0], b[5:0]};

    always_comb
    begin
        needed_next   = needed_reg;
        seen_next     = seen_reg;
        partial_next  = partial_reg;
        take_lead     = 1'b0;
        lead_repl     = 1'b0;
        flush_cnt     = '0;
        job.repl_cnt  = '0;
        job.has_value = 1'b0;
        job.value     = '0;

        if (needed_reg == 2'd0)
        begin
            take_lead = 1'b1;
        end
        else if (b[7:6] == 2'b10)
        begin
            if (seen_inc >= needed_reg)
            begin
                // sequence complete: emit the code point and close
                job.has_value = 1'b1;
                job.value     = pc_ext;
                needed_next   = 2'd0;
                seen_next     = 2'd0;
                partial_next  = '0;
            end
            else if (eot)
            begin
                // truncated: one replacement for the lead and each continuation
                flush_cnt    = {1'b0, seen_inc} + 3'd1;
                needed_next  = 2'd0;
                seen_next    = 2'd0;
                partial_next = '0;
            end
            else
            begin
                partial_next = pc_ext;
                seen_next    = seen_inc;
            end
        end
        else
        begin
            // broken sequence: flush it, then decode this byte as a lead
            flush_cnt    = {1'b0, seen_reg} + 3'd1;
            needed_next  = 2'd0;
            seen_next    = 2'd0;
            partial_next = '0;
            take_lead    = 1'b1;
        end

        if (take_lead)
        begin
            if (!b[7])
            begin
                job.has_value = 1'b1;
                job.value     = {{(CP_W-BYTE_W){1'b0}}, b};
            end
            else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110)
            begin
                if (eot)
                begin
                    lead_repl = 1'b1;
                end
                else
                begin
                    seen_next = 2'd0;
                    if (b[7:5] == 3'b110)
                    begin
                        needed_next  = 2'd1;
                        partial_next = {{(CP_W-5){1'b0}}, b[4:0]};
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        needed_next  = 2'd2;
                        partial_next = {{(CP_W-4){1'b0}}, b[3:0]};
                    end
                    else
                    begin
                        needed_next  = 2'd3;
                        partial_next = {{(CP_W-3){1'b0}}, b[2:0]};
                    end
                end
            end
            else
            begin
                lead_repl = 1'b1;
            end
        end

        job.repl_cnt = flush_cnt + {{(REPL_W-1){1'b0}}, lead_repl};
    end

    assign push = accept && (job.repl_cnt != '0 || job.has_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_reg  <= 2'd0;
            seen_reg    <= 2'd0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            needed_reg  <= needed_next;
            seen_reg    <= seen_next;
            partial_reg <= partial_next;
        end
    end

endmodule

FILE: rtl/u8g_queue.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module u8g_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  u8g_pkg::job_t push_data,
    input  logic          pop,
    output u8g_pkg::job_t pop_data,
    output logic          empty,
    output logic          full
);
    import u8g_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/u8g_back.sv
// Back end: expands each job into result items, looks up glyph slots, registers the output.
`timescale 1ns / 1ps

module u8g_back (
    input  logic               clk,
    input  logic               rst_n,
    input  u8g_pkg::cfg_t      cfg,
    input  u8g_pkg::job_t      head,
    input  logic               q_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output u8g_pkg::out_item_t out_item
);
    import u8g_pkg::*;

    logic [REPL_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg;

    logic [REPL_W-1:0] total;
    logic              load;
    logic              last;
    logic              is_repl;
    logic [CP_W-1:0]   cp;

    assign total   = head.repl_cnt + {{(REPL_W-1){1'b0}}, head.has_value};
    assign is_repl = (idx_reg < head.repl_cnt);
    assign cp      = is_repl ? cfg.replacement_code : head.value;
    assign last    = (idx_reg == total - 1'b1);
    assign load    = !q_empty && (!out_valid_reg || !out_stall);
    assign pop     = load && last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = last ? '0 : idx_reg + 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg.code_point     <= cp;
            out_item_reg.glyph_slot     <= slot_of(cp, cfg.missing_slot);
            out_item_reg.is_replacement <= is_repl;
            out_item_reg.last_of_run    <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: rtl/utf8_decode_glyph_slot.sv
// Top level of the UTF-8 decoder with glyph slot lookup.
`timescale 1ns / 1ps

// Takes one byte of UTF-8 text per input item and returns, per decoded
// character, its code point and its atlas glyph slot. A byte that completes a
// character, or an ASCII byte, gives one result; a byte that opens or extends
// a sequence gives none; a malformed or truncated sequence gives one
// replacement item for the lead byte and one for each continuation already
// taken, after which a breaking byte is decoded again as a lead. One byte may
// thus give up to four result items, the last marked with last_of_run.
// Rate: one byte is accepted every cycle while each byte yields at most one
// result and the output does not stall; the back end delivers one result
// item per cycle unless stalled, a byte with more results holds it longer,
// and the input stalls once the job queue (QUEUE_DEPTH entries) is full. Jobs
// are queued, results registered at the back end's output. No overlong or
// surrogate check is made. The user must write configuration (replacement
// code, missing slot) only while idle; the block does not enforce it.

module utf8_decode_glyph_slot #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  u8g_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output u8g_pkg::out_item_t                 out_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [u8g_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [u8g_pkg::CP_W-1:0]           cfg_data
);
    import u8g_pkg::*;

    cfg_t cfg_reg;
    job_t job;
    job_t head;
    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;

    // Always take configuration writes; indexes beyond the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.replacement_code <= RESET_REPLACEMENT_CODE;
            cfg_reg.missing_slot     <= RESET_MISSING_SLOT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REPLACEMENT_CODE: cfg_reg.replacement_code <= cfg_data;
                CFG_MISSING_SLOT:     cfg_reg.missing_slot     <= cfg_data[SLOT_W-1:0];
                default:              ;
            endcase
        end
    end

    // Front: classify each byte against the open sequence, post a job
    u8g_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .queue_full (q_full),
        .push       (q_push),
        .job        (job)
    );

    // Queue: decouple the front from the back so each stalls on its own
    u8g_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (job),
        .pop       (q_pop),
        .pop_data  (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back: expand jobs into result items, one per cycle while the output does not stall
    u8g_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

`ifndef SYNTHESIS
    // A posted job always carries at least one result item
    a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (job.repl_cnt != '0 || job.has_value))
        else $error("job posted with no result items");

    // No byte gives more than four result items
    a_job_max_four: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (({1'b0, job.repl_cnt} + {3'b000, job.has_value}) <= 4'd4))
        else $error("job exceeds four result items");

    // The back end only retires a job that is present
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job queue popped while empty");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the UTF-8 decoder with glyph slot lookup.
`timescale 1ns / 1ps

module tb_top;

    import u8g_pkg::*;

    // Register indexes past the last real register; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = 2'd3;

    // Allow generous slack for a byte's results to reach the output
    localparam int SETTLE_CYCLES  = 8;
    // Cycles with no item moving on any channel before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;

    // One row of the directed table: the byte, its end flag and, where the answer
    // is obvious, the single result it must give
    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              eot;
        logic              typed;
        logic [CP_W-1:0]   cp;
        logic [SLOT_W-1:0] slot;
        logic              repl;
    } stim_row_t;

    logic clk;
    logic rst_n;

    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CP_W-1:0]      cfg_data;

    // Decoder state and register copies kept alongside the block
    logic [CP_W-1:0]   dec_partial;
    logic [1:0]        dec_needed;
    logic [1:0]        dec_seen;
    logic [CP_W-1:0]   cur_repl_code;
    logic [SLOT_W-1:0] cur_missing_slot;

    out_item_t glyph_burst[$];     // results of the byte being decoded
    out_item_t pending_glyphs[$];  // results still owed by the block
    logic [BYTE_W-1:0] text_bytes[$];
    stim_row_t directed_rows[$];

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int glyphs_checked;
    int reg_writes;
    int mismatches;
    int quiet_cycles;

    out_item_t got_glyph;
    out_item_t want_glyph;

    utf8_decode_glyph_slot dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Atlas lookup: printable ASCII, the Cyrillic block, a few extras, else the missing slot
    function automatic logic [SLOT_W-1:0] atlas_slot(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] offset;
        if (cp >= 21'h000020 && cp <= 21'h00007E)
            offset = cp - 21'h000020;
        else if (cp >= 21'h000410 && cp <= 21'h00044F)
            offset = cp - 21'h000410 + 21'd96;
        else if (cp == 21'h000401)
            offset = 21'd160;
        else if (cp == 21'h000451)
            offset = 21'd161;
        else if (cp == 21'h0000AB)
            offset = 21'd162;
        else if (cp == 21'h0000BB)
            offset = 21'd163;
        else if (cp == 21'h002014)
            offset = 21'd164;
        else
            offset = {13'b0, cur_missing_slot};
        return offset[SLOT_W-1:0];
    endfunction

    function automatic void emit_glyph(input logic [CP_W-1:0] cp, input logic repl);
        out_item_t r;
        r.code_point     = cp;
        r.glyph_slot     = atlas_slot(cp);
        r.is_replacement = repl;
        r.last_of_run    = 1'b0;
        glyph_burst = {glyph_burst, r};
    endfunction

    // Close an open sequence: one replacement for the lead and one per continuation taken
    function automatic void flush_sequence();
        repeat ({30'b0, dec_seen} + 32'd1)
            emit_glyph(cur_repl_code, 1'b1);
        dec_partial = '0;
        dec_needed  = 2'd0;
        dec_seen    = 2'd0;
    endfunction

    function automatic void take_lead(input logic [BYTE_W-1:0] b, input logic eot);
        if (b[7] == 1'b0)
        begin
            emit_glyph({13'b0, b}, 1'b0);
            return;
        end
        if (b[7:5] == 3'b110)
        begin
            dec_needed  = 2'd1;
            dec_partial = {16'b0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            dec_needed  = 2'd2;
            dec_partial = {17'b0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            dec_needed  = 2'd3;
            dec_partial = {18'b0, b[2:0]};
        end
        else
        begin
            // stray continuation or a byte that can never lead
            emit_glyph(cur_repl_code, 1'b1);
            return;
        end
        dec_seen = 2'd0;
        // a lead that is also the last byte of the text is truncated at once
        if (eot)
            flush_sequence();
    endfunction

    // Work out every result that one accepted byte causes, into glyph_burst
    function automatic void decode_byte(input in_item_t it);
        logic [BYTE_W-1:0] b;
        b = it.byte_in;
        glyph_burst.delete();
        if (dec_needed == 2'd0)
            take_lead(b, it.end_of_text);
        else if (b[7:6] == 2'b10)
        begin
            dec_partial = {dec_partial[14:0], b[5:0]};
            dec_seen    = dec_seen + 2'd1;
            if (dec_seen >= dec_needed)
            begin
                emit_glyph(dec_partial, 1'b0);
                dec_partial = '0;
                dec_needed  = 2'd0;
                dec_seen    = 2'd0;
            end
            else if (it.end_of_text)
                flush_sequence();
        end
        else
        begin
            // broken sequence: flush it, then decode the breaking byte afresh
            flush_sequence();
            take_lead(b, it.end_of_text);
        end
        if (glyph_burst.size() > 0)
            glyph_burst[glyph_burst.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [CP_W-1:0] want,
                                        input logic [CP_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void add_row(input logic [BYTE_W-1:0] b, input logic eot,
                                    input logic typed, input logic [CP_W-1:0] cp,
                                    input logic [SLOT_W-1:0] slot, input logic repl);
        stim_row_t r;
        r.byte_val = b;
        r.eot      = eot;
        r.typed    = typed;
        r.cp       = cp;
        r.slot     = slot;
        r.repl     = repl;
        directed_rows = {directed_rows, r};
    endfunction

    // Append one byte to the text being gathered
    function automatic void add_text_byte(input logic [BYTE_W-1:0] b);
        text_bytes = {text_bytes, b};
    endfunction

    // Offer one byte, idling at random first; hold the item until it is taken, then
    // record what it owes. A typed row owes its typed result instead of the predicted one.
    task automatic send_byte(input in_item_t it, input logic typed,
                             input out_item_t typed_glyph);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        items_sent++;
        decode_byte(it);
        if (typed)
            pending_glyphs = {pending_glyphs, typed_glyph};
        else
            foreach (glyph_burst[i])
                pending_glyphs = {pending_glyphs, glyph_burst[i]};
    endtask

    // Send the bytes gathered in text_bytes, flagging the last one when eot is set
    task automatic send_text(input logic eot);
        in_item_t  it;
        out_item_t none;
        int        last;
        none = '0;
        last = text_bytes.size() - 1;
        for (int i = 0; i <= last; i++)
        begin
            it.byte_in     = text_bytes[i];
            it.end_of_text = eot && (i == last);
            send_byte(it, 1'b0, none);
        end
        text_bytes.delete();
    endtask

    // Encode a code point in n bytes; the lead keeps only the bits that fit
    task automatic send_code_point(input logic [CP_W-1:0] cp, input int n, input logic eot);
        case (n)
            1:
            begin
                add_text_byte({1'b0, cp[6:0]});
            end
            2:
            begin
                add_text_byte({3'b110, cp[10:6]});
                add_text_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                add_text_byte({4'b1110, cp[15:12]});
                add_text_byte({2'b10, cp[11:6]});
                add_text_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                add_text_byte({5'b11110, cp[20:18]});
                add_text_byte({2'b10, cp[17:12]});
                add_text_byte({2'b10, cp[11:6]});
                add_text_byte({2'b10, cp[5:0]});
            end
        endcase
        send_text(eot);
    endtask

    // One random character: mostly well-formed text, some broken or truncated
    // sequences and some raw noise
    task automatic send_random_char();
        int               kind;
        int               pick;
        int               n;
        int               m;
        logic             eot;
        logic [31:0]      rnd;
        logic [CP_W-1:0]  cp;
        logic [BYTE_W-1:0] b;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        eot  = ($urandom_range(0, 9) == 0);
        rnd  = $urandom;
        if (kind < 25)
            send_code_point({14'b0, rnd[6:0]}, 1, eot);
        else if (kind < 50)
        begin
            // characters that have a slot of their own
            case (pick)
                0:       cp = 21'h000401;
                1:       cp = 21'h000451;
                2:       cp = 21'h0000AB;
                3:       cp = 21'h0000BB;
                4:       cp = 21'h002014;
                default: cp = 21'h000410 + {15'b0, rnd[5:0]};
            endcase
            send_code_point(cp, (cp < 21'h000800) ? 2 : 3, eot);
        end
        else if (kind < 60)
            send_code_point({10'b0, rnd[10:0]}, 2, eot);
        else if (kind < 68)
            send_code_point({5'b0, rnd[15:0]}, 3, eot);
        else if (kind < 76)
            send_code_point(rnd[20:0], 4, eot);
        else if (kind < 88)
        begin
            // open a sequence, take fewer continuations than it needs, then
            // either end the text there or break it with a non-continuation
            n = $urandom_range(2, 4);
            m = $urandom_range(0, n - 2);
            case (n)
                2:       add_text_byte({3'b110, rnd[4:0]});
                3:       add_text_byte({4'b1110, rnd[3:0]});
                default: add_text_byte({5'b11110, rnd[2:0]});
            endcase
            for (int i = 0; i < m; i++)
            begin
                rnd = $urandom;
                add_text_byte({2'b10, rnd[5:0]});
            end
            if (rnd[31])
                send_text(1'b1);
            else
            begin
                b = rnd[15:8];
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                add_text_byte(b);
                send_text(eot);
            end
        end
        else
        begin
            add_text_byte(rnd[7:0]);
            send_text(eot);
        end
    endtask

    // Drop valid and hold off until the block owes nothing
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_glyphs.size() != 0);
    endtask

    // Write one register once the block is idle; let a byte that owes nothing settle first
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CP_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_glyphs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == CFG_REPLACEMENT_CODE)
            cur_repl_code = data;
        else if (idx == CFG_MISSING_SLOT)
            cur_missing_slot = data[SLOT_W-1:0];
    endtask

    task automatic run_random(input int quota);
        int target;
        int chars;
        target = items_sent + quota;
        chars  = 0;
        while (items_sent < target)
        begin
            send_random_char();
            chars++;
            // now and then let the output side empty completely
            if (chars % 40 == 20)
                hold_until_drained();
        end
    endtask

    // Receiver: stall at random at the rate the current phase sets
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Compare each result taken with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_glyph = out_item;
            if (pending_glyphs.size() == 0)
            begin
                $error("unexpected result: code_point %0h glyph_slot %0h",
                       got_glyph.code_point, got_glyph.glyph_slot);
                mismatches++;
            end
            else
            begin
                want_glyph = pending_glyphs.pop_front();
                check_field("code_point", want_glyph.code_point, got_glyph.code_point);
                check_field("glyph_slot", {13'b0, want_glyph.glyph_slot},
                            {13'b0, got_glyph.glyph_slot});
                check_field("is_replacement", {20'b0, want_glyph.is_replacement},
                            {20'b0, got_glyph.is_replacement});
                check_field("last_of_run", {20'b0, want_glyph.last_of_run},
                            {20'b0, got_glyph.last_of_run});
            end
            glyphs_checked++;
        end
    end

    // Watchdog: end the run if no item moves on any channel for too long
    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        in_item_t  it;
        out_item_t want;
        logic [31:0] rnd;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_REPLACEMENT_CODE;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent     = 0;
        glyphs_checked = 0;
        reg_writes     = 0;
        mismatches     = 0;

        dec_partial      = '0;
        dec_needed       = 2'd0;
        dec_seen         = 2'd0;
        cur_repl_code    = RESET_REPLACEMENT_CODE;
        cur_missing_slot = RESET_MISSING_SLOT;

        // Directed table, run on the reset register values
        //       byte   eot   typed code point  slot  repl
        add_row(8'h41, 1'b0, 1'b1, 21'h000041, 8'd33, 1'b0);  // plain ASCII letter
        add_row(8'h00, 1'b0, 1'b1, 21'h000000, 8'd95, 1'b0);  // lowest control byte
        add_row(8'h7F, 1'b1, 1'b1, 21'h00007F, 8'd95, 1'b0);  // DEL, ends a text
        add_row(8'h80, 1'b0, 1'b1, 21'h00FFFD, 8'd95, 1'b1);  // stray continuation
        add_row(8'hF8, 1'b0, 1'b1, 21'h00FFFD, 8'd95, 1'b1);  // never a lead
        add_row(8'hFF, 1'b1, 1'b1, 21'h00FFFD, 8'd95, 1'b1);  // top byte, end flag
        add_row(8'hD0, 1'b0, 1'b0, '0, '0, 1'b0);             // first Cyrillic letter
        add_row(8'h90, 1'b0, 1'b1, 21'h000410, 8'd96, 1'b0);
        add_row(8'hD1, 1'b0, 1'b0, '0, '0, 1'b0);             // last Cyrillic letter
        add_row(8'h8F, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hD1, 1'b0, 1'b0, '0, '0, 1'b0);             // small io
        add_row(8'h91, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hE2, 1'b0, 1'b0, '0, '0, 1'b0);             // em dash
        add_row(8'h80, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'h94, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hC2, 1'b0, 1'b0, '0, '0, 1'b0);             // right guillemet
        add_row(8'hBB, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hF4, 1'b0, 1'b0, '0, '0, 1'b0);             // highest Unicode scalar
        add_row(8'h8F, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hBF, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hBF, 1'b0, 1'b1, 21'h10FFFF, 8'd95, 1'b0);
        add_row(8'hF0, 1'b0, 1'b0, '0, '0, 1'b0);             // four-byte form broken
        add_row(8'h90, 1'b0, 1'b0, '0, '0, 1'b0);             // by ASCII after two
        add_row(8'h80, 1'b0, 1'b0, '0, '0, 1'b0);             // continuations
        add_row(8'h41, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hE2, 1'b0, 1'b0, '0, '0, 1'b0);             // text ends mid-sequence
        add_row(8'h80, 1'b1, 1'b0, '0, '0, 1'b0);
        add_row(8'hC3, 1'b1, 1'b1, 21'h00FFFD, 8'd95, 1'b1);  // lead on the last byte

        // Hold reset, then release it at an edge
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        // Sender idles lightly, receiver stalls heavily
        send_idle_pct = 35;
        recv_idle_pct = 60;
        foreach (directed_rows[r])
        begin
            it.byte_in          = directed_rows[r].byte_val;
            it.end_of_text      = directed_rows[r].eot;
            want.code_point     = directed_rows[r].cp;
            want.glyph_slot     = directed_rows[r].slot;
            want.is_replacement = directed_rows[r].repl;
            want.last_of_run    = 1'b1;
            send_byte(it, directed_rows[r].typed, want);
        end

        // Extremes: all-ones replacement, missing slot zero with upper data bits masked
        rnd = $urandom;
        write_reg(CFG_REPLACEMENT_CODE, 21'h1FFFFF);
        write_reg(CFG_MISSING_SLOT, 21'h1FFF00);
        write_reg(SPARE_INDEX_LO, rnd[20:0]);
        run_random(115);

        // Swap the idling sides; replacement zero, missing slot all ones
        send_idle_pct = 60;
        recv_idle_pct = 35;
        rnd = $urandom;
        write_reg(CFG_REPLACEMENT_CODE, 21'h000000);
        write_reg(CFG_MISSING_SLOT, 21'h0000FF);
        write_reg(SPARE_INDEX_HI, rnd[20:0]);
        run_random(115);

        // No idling at all; replacement that has a slot of its own
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rnd = $urandom;
        write_reg(CFG_REPLACEMENT_CODE, 21'h000451);
        write_reg(CFG_MISSING_SLOT, rnd[20:0]);
        run_random(115);

        // Drain, then give the block time to show any result it should not
        in_valid <= 1'b0;
        while (pending_glyphs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (pending_glyphs.size() != 0)
        begin
            $error("%0d results never arrived", pending_glyphs.size());
            mismatches++;
        end

        $display("Fed %0d bytes (directed, well-formed, broken and noise) and checked %0d results",
                 items_sent, glyphs_checked);
        $display("over %0d register writes, with idling on either side and none; %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
